// ===== hdl/ccs_pkg.sv =====
// ----------------------------------------------------------------------------
// ccs_pkg
// Scanner modes, character codes and the queue entry type of the stripper.
// ----------------------------------------------------------------------------
package ccs_pkg;

  typedef enum logic [3:0] {
    MODE_CODE       = 4'd0,
    MODE_SLASH      = 4'd1,
    MODE_LINE       = 4'd2,
    MODE_BLOCK      = 4'd3,
    MODE_BLOCK_STAR = 4'd4,
    MODE_STR        = 4'd5,
    MODE_STR_ESC    = 4'd6,
    MODE_CHR        = 4'd7,
    MODE_CHR_ESC    = 4'd8
  } scan_mode_e;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // one request worth of output bytes
  typedef struct packed {
    logic       two;
    logic [7:0] b0;
    logic [7:0] b1;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } qword_t;

endpackage

// ===== hdl/ccs_front.sv =====
// ----------------------------------------------------------------------------
// ccs_front
// Scanner state machine: classifies each byte and forms up to two output bytes.
// ----------------------------------------------------------------------------
module ccs_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      in_byte_i,
  input  logic            final_req_i,
  input  logic            q_full_i,
  output ccs_pkg::qword_t push_o
);

  ccs_pkg::scan_mode_e mode_q, mode_d;
  logic [1:0] e_cnt;
  logic [7:0] e0, e1;
  logic       accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ccs_pkg::MODE_CODE;
    end else if (accept) begin
      mode_q <= mode_d;
    end
  end

  always_comb begin
    logic [7:0] b;
    logic       put_b;
    logic       put_slash;
    logic       slash_first;
    b           = in_byte_i;
    mode_d      = mode_q;
    put_b       = 1'b0;
    put_slash   = 1'b0;
    slash_first = 1'b0;
    unique case (mode_q)
      ccs_pkg::MODE_SLASH: begin
        if (b == ccs_pkg::CH_SLASH) begin
          mode_d = ccs_pkg::MODE_LINE;
        end else if (b == ccs_pkg::CH_STAR) begin
          mode_d = ccs_pkg::MODE_BLOCK;
        end else begin
          // held slash goes out ahead of this byte
          slash_first = 1'b1;
          put_b       = 1'b1;
          if (b == ccs_pkg::CH_DQUOTE) begin
            mode_d = ccs_pkg::MODE_STR;
          end else if (b == ccs_pkg::CH_SQUOTE) begin
            mode_d = ccs_pkg::MODE_CHR;
          end else begin
            mode_d = ccs_pkg::MODE_CODE;
          end
        end
      end
      ccs_pkg::MODE_LINE: begin
        if (b == ccs_pkg::CH_NL) begin
          put_b  = 1'b1;
          mode_d = ccs_pkg::MODE_CODE;
        end
      end
      ccs_pkg::MODE_BLOCK: begin
        if (b == ccs_pkg::CH_STAR) begin
          mode_d = ccs_pkg::MODE_BLOCK_STAR;
        end
      end
      ccs_pkg::MODE_BLOCK_STAR: begin
        if (b == ccs_pkg::CH_SLASH) begin
          mode_d = ccs_pkg::MODE_CODE;
        end else if (b != ccs_pkg::CH_STAR) begin
          mode_d = ccs_pkg::MODE_BLOCK;
        end
      end
      ccs_pkg::MODE_STR: begin
        put_b = 1'b1;
        if (b == ccs_pkg::CH_BSLASH) begin
          mode_d = ccs_pkg::MODE_STR_ESC;
        end else if (b == ccs_pkg::CH_DQUOTE) begin
          mode_d = ccs_pkg::MODE_CODE;
        end
      end
      ccs_pkg::MODE_STR_ESC: begin
        put_b  = 1'b1;
        mode_d = ccs_pkg::MODE_STR;
      end
      ccs_pkg::MODE_CHR: begin
        put_b = 1'b1;
        if (b == ccs_pkg::CH_BSLASH) begin
          mode_d = ccs_pkg::MODE_CHR_ESC;
        end else if (b == ccs_pkg::CH_SQUOTE) begin
          mode_d = ccs_pkg::MODE_CODE;
        end
      end
      ccs_pkg::MODE_CHR_ESC: begin
        put_b  = 1'b1;
        mode_d = ccs_pkg::MODE_CHR;
      end
      default: begin
        if (b == ccs_pkg::CH_SLASH) begin
          mode_d = ccs_pkg::MODE_SLASH;
        end else begin
          put_b = 1'b1;
          if (b == ccs_pkg::CH_DQUOTE) begin
            mode_d = ccs_pkg::MODE_STR;
          end else if (b == ccs_pkg::CH_SQUOTE) begin
            mode_d = ccs_pkg::MODE_CHR;
          end else begin
            mode_d = ccs_pkg::MODE_CODE;
          end
        end
      end
    endcase

    // flush a held slash on the last byte of the stream
    if (final_req_i) begin
      if (mode_d == ccs_pkg::MODE_SLASH) begin
        put_slash = 1'b1;
      end
      mode_d = ccs_pkg::MODE_CODE;
    end

    e_cnt = 2'd0;
    e0    = b;
    e1    = b;
    if (slash_first) begin
      e0    = ccs_pkg::CH_SLASH;
      e_cnt = 2'd2;
    end else if (put_b) begin
      e_cnt = 2'd1;
    end else if (put_slash) begin
      e0    = ccs_pkg::CH_SLASH;
      e_cnt = 2'd1;
    end
  end

  assign push_o.valid     = accept && (e_cnt != 2'd0);
  assign push_o.entry.two = (e_cnt == 2'd2);
  assign push_o.entry.b0  = e0;
  assign push_o.entry.b1  = e1;

endmodule

// ===== hdl/ccs_queue.sv =====
// ----------------------------------------------------------------------------
// ccs_queue
// Two-entry queue of output requests between scanner and output stage.
// ----------------------------------------------------------------------------
module ccs_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ccs_pkg::qword_t push_i,
  output logic            full_o,
  output ccs_pkg::qword_t head_o,
  input  logic            pop_i
);

  ccs_pkg::entry_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o       = (cnt_q == 2'd2);
  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.entry = mem_q[rd_ptr_q];
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

// ===== hdl/ccs_back.sv =====
// ----------------------------------------------------------------------------
// ccs_back
// Output stage: sends the bytes of each queued request one per cycle while out_stall_i is low.
// ----------------------------------------------------------------------------
module ccs_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ccs_pkg::qword_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            run_last_o
);

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       run_last_q, run_last_d;
  logic       pend_valid_q, pend_valid_d;
  logic [7:0] pend_byte_q, pend_byte_d;
  logic       load_ok;

  assign load_ok = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_byte_d   = out_byte_q;
    run_last_d   = run_last_q;
    pend_valid_d = pend_valid_q;
    pend_byte_d  = pend_byte_q;
    pop_o        = 1'b0;
    if (load_ok) begin
      if (pend_valid_q) begin
        // second byte of a two-byte request
        out_valid_d  = 1'b1;
        out_byte_d   = pend_byte_q;
        run_last_d   = 1'b1;
        pend_valid_d = 1'b0;
      end else if (head_i.valid) begin
        pop_o        = 1'b1;
        out_valid_d  = 1'b1;
        out_byte_d   = head_i.entry.b0;
        run_last_d   = !head_i.entry.two;
        pend_valid_d = head_i.entry.two;
        pend_byte_d  = head_i.entry.b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q  <= out_byte_d;
    run_last_q  <= run_last_d;
    pend_byte_q <= pend_byte_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = run_last_q;

endmodule

// ===== hdl/c_comment_stripper.sv =====
// ----------------------------------------------------------------------------
// c_comment_stripper
// Removes C line and block comments from a byte stream, honoring literals.
// ----------------------------------------------------------------------------
// path: an accepted byte is written into the queue, then loaded into the output register
// throughput: one input byte per cycle while in_stall_o is low; a two-byte result (held
//   slash and the byte after it) leaves the output stage one byte at a time
// reset: scanner returns to normal code mode, queue and output stage empty
module c_comment_stripper (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       final_req_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o
);

  ccs_pkg::qword_t push, head;
  logic            q_full, pop;

  ccs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .final_req_i (final_req_i),
    .q_full_i    (q_full),
    .push_o      (push)
  );

  ccs_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .head_o (head),
    .pop_i  (pop)
  );

  ccs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o)
  );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives C source byte streams into c_comment_stripper and checks every
// stripped output byte and its run_last flag against a scanner model kept
// here, under random idling on the request side and random output stalls.
// ----------------------------------------------------------------------------
module testbench;

  localparam int NUM_REQS   = 900;
  localparam int QUIET_REQS = 120;
  localparam int CYCLE_MAX  = 600000;
  localparam int DIR_ROWS   = 31;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } strip_byte_t;

  typedef struct packed {
    logic [7:0] b;
    logic       fin;
  } src_req_t;

  // directed row: typed rows carry their own expected bytes
  typedef struct packed {
    logic [7:0] b;
    logic       fin;
    logic       typed;
    logic [1:0] n;
    logic [7:0] e0;
    logic [7:0] e1;
  } dir_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i = 8'h00;
  logic       final_req_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       run_last_o;

  ccs_pkg::scan_mode_e scan_st;
  strip_byte_t         strip_q[$];
  src_req_t            src_q[$];
  dir_row_t            dir_tab [0:DIR_ROWS-1];

  int  errors = 0;
  int  cycles = 0;
  int  reqs_sent = 0;
  int  finals_sent = 0;
  int  bytes_checked = 0;
  int  stall_left = 0;
  bit  idle_on = 1'b1;
  bit  quiet = 1'b0;

  c_comment_stripper i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .final_req_i(final_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_byte_o (out_byte_o),
    .run_last_o (run_last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_MAX) begin
      $display("timeout after %0d cycles, %0d bytes still pending", cycles, strip_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  // mode after a byte seen in code with no slash held
  function automatic ccs_pkg::scan_mode_e code_next(input logic [7:0] b);
    if (b == ccs_pkg::CH_SLASH) return ccs_pkg::MODE_SLASH;
    if (b == ccs_pkg::CH_DQUOTE) return ccs_pkg::MODE_STR;
    if (b == ccs_pkg::CH_SQUOTE) return ccs_pkg::MODE_CHR;
    return ccs_pkg::MODE_CODE;
  endfunction

  function automatic int strip_step(input logic [7:0] b, input logic fin,
                                    output logic [7:0] o0, output logic [7:0] o1);
    logic [7:0] ob [2];
    int         n;
    n = 0;
    ob[0] = 8'h00;
    ob[1] = 8'h00;
    case (scan_st)
      ccs_pkg::MODE_SLASH: begin
        if (b == ccs_pkg::CH_SLASH) begin
          scan_st = ccs_pkg::MODE_LINE;
        end else if (b == ccs_pkg::CH_STAR) begin
          scan_st = ccs_pkg::MODE_BLOCK;
        end else begin
          ob[n] = ccs_pkg::CH_SLASH; n++;
          if (b != ccs_pkg::CH_SLASH) begin
            ob[n] = b; n++;
          end
          scan_st = code_next(b);
        end
      end
      ccs_pkg::MODE_LINE: begin
        if (b == ccs_pkg::CH_NL) begin
          ob[n] = b; n++;
          scan_st = ccs_pkg::MODE_CODE;
        end
      end
      ccs_pkg::MODE_BLOCK: begin
        if (b == ccs_pkg::CH_STAR) scan_st = ccs_pkg::MODE_BLOCK_STAR;
      end
      ccs_pkg::MODE_BLOCK_STAR: begin
        if (b == ccs_pkg::CH_SLASH) scan_st = ccs_pkg::MODE_CODE;
        else if (b != ccs_pkg::CH_STAR) scan_st = ccs_pkg::MODE_BLOCK;
      end
      ccs_pkg::MODE_STR: begin
        ob[n] = b; n++;
        if (b == ccs_pkg::CH_BSLASH) scan_st = ccs_pkg::MODE_STR_ESC;
        else if (b == ccs_pkg::CH_DQUOTE) scan_st = ccs_pkg::MODE_CODE;
      end
      ccs_pkg::MODE_STR_ESC: begin
        ob[n] = b; n++;
        scan_st = ccs_pkg::MODE_STR;
      end
      ccs_pkg::MODE_CHR: begin
        ob[n] = b; n++;
        if (b == ccs_pkg::CH_BSLASH) scan_st = ccs_pkg::MODE_CHR_ESC;
        else if (b == ccs_pkg::CH_SQUOTE) scan_st = ccs_pkg::MODE_CODE;
      end
      ccs_pkg::MODE_CHR_ESC: begin
        ob[n] = b; n++;
        scan_st = ccs_pkg::MODE_CHR;
      end
      default: begin
        if (b != ccs_pkg::CH_SLASH) begin
          ob[n] = b; n++;
        end
        scan_st = code_next(b);
      end
    endcase
    if (fin) begin
      // a slash still held at end of stream is flushed
      if (scan_st == ccs_pkg::MODE_SLASH) begin
        ob[n] = ccs_pkg::CH_SLASH; n++;
      end
      scan_st = ccs_pkg::MODE_CODE;
    end
    o0 = ob[0];
    o1 = ob[1];
    return n;
  endfunction

  function automatic void push_bytes(input int n, input logic [7:0] o0,
                                     input logic [7:0] o1);
    if (n >= 1) strip_q.push_back('{data: o0, last: (n == 1)});
    if (n == 2) strip_q.push_back('{data: o1, last: 1'b1});
  endfunction

  function automatic void note_mismatch(input string what, input logic [7:0] exp_v,
                                        input logic [7:0] act_v);
    errors++;
    if (errors <= 10) begin
      $display("mismatch at cycle %0d: %s expected %h got %h", cycles, what, exp_v, act_v);
    end
  endfunction

  // output checker
  always @(posedge clk_i) begin
    strip_byte_t exp_b;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (strip_q.size() == 0) begin
        note_mismatch("unexpected byte", 8'h00, out_byte_o);
      end else begin
        exp_b = strip_q.pop_front();
        bytes_checked++;
        if (out_byte_o !== exp_b.data) note_mismatch("out_byte", exp_b.data, out_byte_o);
        if (run_last_o !== exp_b.last) begin
          note_mismatch("run_last", 8'(exp_b.last), 8'(run_last_o));
        end
      end
    end
  end

  // output stall in random bursts
  always @(posedge clk_i) begin
    if (!rst_ni || quiet) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall_i <= 1'b1;
      stall_left <= $urandom_range(0, 16);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_req(input logic [7:0] b, input logic fin);
    int gap;
    if (idle_on && !quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i <= b;
    final_req_i <= fin;
    do @(posedge clk_i); while (in_stall_o);
    reqs_sent++;
    if (fin) finals_sent++;
  endtask

  task automatic drain_all();
    in_valid_i <= 1'b0;
    while (strip_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic void add_src(input logic [7:0] b);
    src_q.push_back('{b: b, fin: 1'b0});
  endfunction

  // one random token of C-like text, mostly well formed
  function automatic void make_token();
    int kind;
    int len;
    kind = $urandom_range(0, 9);
    len = $urandom_range(0, 6);
    case (kind)
      0, 1: begin
        for (int i = 0; i <= len; i++) add_src(8'($urandom_range(32, 126)));
      end
      2: begin
        add_src(ccs_pkg::CH_SLASH); add_src(ccs_pkg::CH_SLASH);
        for (int i = 0; i < len; i++) add_src(8'($urandom_range(0, 255)));
        add_src(ccs_pkg::CH_NL);
      end
      3: begin
        add_src(ccs_pkg::CH_SLASH); add_src(ccs_pkg::CH_STAR);
        for (int i = 0; i < len; i++) begin
          add_src($urandom_range(0, 3) == 0 ? ccs_pkg::CH_STAR : 8'($urandom_range(0, 255)));
        end
        repeat ($urandom_range(1, 3)) add_src(ccs_pkg::CH_STAR);
        add_src(ccs_pkg::CH_SLASH);
      end
      4: begin
        add_src(ccs_pkg::CH_DQUOTE);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 3) == 0) add_src(ccs_pkg::CH_BSLASH);
          add_src(8'($urandom_range(0, 255)));
        end
        add_src(ccs_pkg::CH_DQUOTE);
      end
      5: begin
        add_src(ccs_pkg::CH_SQUOTE);
        if ($urandom_range(0, 1) == 0) add_src(ccs_pkg::CH_BSLASH);
        add_src(8'($urandom_range(0, 255)));
        add_src(ccs_pkg::CH_SQUOTE);
      end
      6, 7: begin
        // held slash followed by a quote or a random byte, which may itself open a comment
        add_src(ccs_pkg::CH_SLASH);
        case ($urandom_range(0, 3))
          0: add_src(ccs_pkg::CH_DQUOTE);
          1: add_src(ccs_pkg::CH_SQUOTE);
          default: add_src(8'($urandom_range(0, 255)));
        endcase
      end
      default: begin
        for (int i = 0; i <= len % 4; i++) add_src(8'($urandom_range(0, 255)));
      end
    endcase
    // end of stream marks, at token ends and now and then mid token
    if ($urandom_range(0, 14) == 0) src_q[src_q.size() - 1].fin = 1'b1;
    if ($urandom_range(0, 29) == 0) src_q[$urandom_range(0, src_q.size() - 1)].fin = 1'b1;
  endfunction

  initial begin
    logic [7:0] o0, o1;
    int         n;
    src_req_t   r;

    dir_tab = '{
      '{8'h00,              1'b0, 1'b1, 2'd1, 8'h00,             8'h00},
      '{8'hFF,              1'b0, 1'b1, 2'd1, 8'hFF,             8'h00},
      '{ccs_pkg::CH_SLASH,  1'b0, 1'b1, 2'd0, 8'h00,             8'h00},
      '{8'h61,              1'b0, 1'b1, 2'd2, ccs_pkg::CH_SLASH, 8'h61},
      '{ccs_pkg::CH_SLASH,  1'b0, 1'b0, 2'd0, 8'h00,             8'h00},
      '{ccs_pkg::CH_SLASH,  1'b0, 1'b0, 2'd0, 8'h00,             8'h00},
      '{ccs_pkg::CH_DQUOTE, 1'b0, 1'b0, 2'd0, 8'h00,             8'h00},
      '{ccs_pkg::CH_NL,     1'b0, 1'b0, 2'd0, 8'h00,             8'h00},
      '{ccs_pkg::CH_SLASH,  1'b0, 1'b0, 2'd0, 8'h00,             8'h00},
      '{ccs_pkg::CH_STAR,   1'b0, 1'b0, 2'd0, 8'h00,             8'h00},
      '{ccs_pkg::CH_SQUOTE, 1'b0, 1'b0, 2'd0, 8'h00,             8'h00},
      '{ccs_pkg::CH_STAR,   1'b0, 1'b0, 2'd0, 8'h00,             8'h00},
      '{ccs_pkg::CH_STAR,   1'b0, 1'b0, 2'd0, 8'h00,             8'h00},
      '{ccs_pkg::CH_SLASH,  1'b0, 1'b0, 2'd0, 8'h00,             8'h00},
      '{ccs_pkg::CH_SLASH,  1'b0, 1'b0, 2'd0, 8'h00,             8'h00},
      '{ccs_pkg::CH_DQUOTE, 1'b0, 1'b0, 2'd0, 8'h00,             8'h00},
      '{ccs_pkg::CH_SLASH,  1'b0, 1'b0, 2'd0, 8'h00,             8'h00},
      '{ccs_pkg::CH_SLASH,  1'b0, 1'b0, 2'd0, 8'h00,             8'h00},
      '{ccs_pkg::CH_BSLASH, 1'b0, 1'b0, 2'd0, 8'h00,             8'h00},
      '{ccs_pkg::CH_DQUOTE, 1'b0, 1'b0, 2'd0, 8'h00,             8'h00},
      '{ccs_pkg::CH_NL,     1'b0, 1'b0, 2'd0, 8'h00,             8'h00},
      '{ccs_pkg::CH_DQUOTE, 1'b0, 1'b0, 2'd0, 8'h00,             8'h00},
      '{ccs_pkg::CH_SQUOTE, 1'b0, 1'b0, 2'd0, 8'h00,             8'h00},
      '{ccs_pkg::CH_BSLASH, 1'b0, 1'b0, 2'd0, 8'h00,             8'h00},
      '{ccs_pkg::CH_SQUOTE, 1'b0, 1'b0, 2'd0, 8'h00,             8'h00},
      '{ccs_pkg::CH_SQUOTE, 1'b0, 1'b0, 2'd0, 8'h00,             8'h00},
      '{ccs_pkg::CH_SLASH,  1'b1, 1'b1, 2'd1, ccs_pkg::CH_SLASH, 8'h00},
      '{ccs_pkg::CH_SLASH,  1'b0, 1'b0, 2'd0, 8'h00,             8'h00},
      '{ccs_pkg::CH_STAR,   1'b1, 1'b1, 2'd0, 8'h00,             8'h00},
      '{ccs_pkg::CH_DQUOTE, 1'b0, 1'b0, 2'd0, 8'h00,             8'h00},
      '{8'h78,              1'b1, 1'b0, 2'd0, 8'h00,             8'h00}
    };

    scan_st = ccs_pkg::MODE_CODE;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_req(dir_tab[i].b, dir_tab[i].fin);
      n = strip_step(dir_tab[i].b, dir_tab[i].fin, o0, o1);
      if (dir_tab[i].typed) push_bytes(int'(dir_tab[i].n), dir_tab[i].e0, dir_tab[i].e1);
      else push_bytes(n, o0, o1);
    end
    drain_all();

    while (reqs_sent < DIR_ROWS + NUM_REQS) begin
      if (src_q.size() == 0) make_token();
      r = src_q.pop_front();
      if (reqs_sent % 100 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (reqs_sent == DIR_ROWS + NUM_REQS / 2) drain_all();
      if (reqs_sent >= DIR_ROWS + NUM_REQS - QUIET_REQS) quiet = 1'b1;
      send_req(r.b, r.fin);
      n = strip_step(r.b, r.fin, o0, o1);
      push_bytes(n, o0, o1);
    end
    drain_all();
    repeat (20) @(posedge clk_i);
    errors += strip_q.size();

    $display("sent %0d bytes (%0d end-of-stream marks), checked %0d stripped bytes",
             reqs_sent, finals_sent, bytes_checked);
    $display("covered code, line and block comments, literals with escapes, held slashes");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
